>>> src/sapd_pkg.sv
// ----------------------------------------------------------------------------
// sapd_pkg
// shared constants and types for the suffix array builder
// ----------------------------------------------------------------------------
package sapd_pkg;

  localparam int MaxLen  = 1024;
  localparam int IdxW    = $clog2(MaxLen);
  localparam int CntW    = IdxW + 1;
  localparam int CodeW   = 6;
  localparam int AlphaCodes = 53;

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_BUILD  = 2'd1,
    FN_READ   = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_LETTER = 3'd2,
    ST_RANK   = 3'd3,
    ST_PHASE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_READ,
    T_BUILD
  } top_state_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SENT, S_CLR, S_HIST, S_PSUM, S_SCAT, S_CLS0,
    S_SHIFT, S_SCAT2, S_RENUM, S_COPY, S_DONE
  } eng_state_t;

  // host side access to the stores while the engine is idle
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [CodeW-1:0] wdata;
    logic [IdxW-1:0]  raddr;
  } host_t;

endpackage

>>> src/suffix_array_prefix_doubling.sv
// ----------------------------------------------------------------------------
// suffix_array_prefix_doubling
// letter store and suffix array builder by prefix doubling with counting sort
// ----------------------------------------------------------------------------
// response: append, clear and refused requests answer the cycle after the request,
//   a good read after the read state, which holds off new requests meanwhile
// throughput: append and clear take a request every cycle while out_ready is high
// build: sentinel write, counter clearing sweep, histogram, prefix sum, scatter and
//   first classes, then ceil(log2 n) doubling rounds (n = letters+1) of shift, counter
//   clearing, histogram, prefix sum, scatter, renumber and copy
// reset: text length and built flag clear; stores hold nothing until written
module suffix_array_prefix_doubling (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_symbol,
  input  logic [9:0] in_rank,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [9:0] out_position,
  output logic [9:0] out_length
);
  import sapd_pkg::*;

  top_state_t st_r, st_nxt;
  logic [IdxW-1:0] len_r, len_nxt;
  logic            built_r, built_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         status_r, status_nxt;
  logic [IdxW-1:0] pos_r, pos_nxt, olen_r, olen_nxt;

  logic            accept, start, done, is_upper, is_lower;
  logic [CodeW-1:0] code;
  logic [IdxW-1:0] sa_rdata;
  host_t           host;

  // the output register frees the input side as soon as its result is taken
  assign in_ready = (st_r == T_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // letter to class code
  assign is_upper = (in_symbol >= 8'h41) && (in_symbol <= 8'h5a);
  assign is_lower = (in_symbol >= 8'h61) && (in_symbol <= 8'h7a);
  assign code     = is_upper ? CodeW'(in_symbol - 8'h40)
                             : CodeW'(in_symbol - 8'h61 + 8'd27);

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_position = pos_r;
  assign out_length   = olen_r;

  sapd_engine u_engine (
    .clk,
    .rst_n,
    .start,
    .len      (len_r),
    .host,
    .sa_rdata,
    .done
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      len_r       <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      len_r       <= len_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
    olen_r   <= olen_nxt;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      T_IDLE: begin
        if (accept && func_t'(in_func) == FN_BUILD) begin
          st_nxt = T_BUILD;
        end else if (accept && func_t'(in_func) == FN_READ && built_r &&
                     in_rank != '0 && in_rank <= len_r) begin
          st_nxt = T_READ;
        end
      end
      T_READ:  st_nxt = T_IDLE;
      T_BUILD: if (done) st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  // outputs and request handling
  always_comb begin
    len_nxt       = len_r;
    built_nxt     = built_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    olen_nxt      = olen_r;
    start         = 1'b0;
    host.we       = 1'b0;
    host.waddr    = len_r;
    host.wdata    = code;
    host.raddr    = in_rank;
    case (st_r)
      T_IDLE: begin
        if (accept) begin
          status_nxt    = ST_OK;
          pos_nxt       = '0;
          out_valid_nxt = 1'b1;
          case (func_t'(in_func))
            FN_APPEND: begin
              if (built_r) begin
                status_nxt = ST_PHASE;
              end else if (!is_upper && !is_lower) begin
                status_nxt = ST_LETTER;
              end else if (len_r == IdxW'(MaxLen - 1)) begin
                status_nxt = ST_FULL;
              end else begin
                host.we = 1'b1;
                len_nxt = len_r + IdxW'(1);
              end
            end
            FN_BUILD: begin
              start         = 1'b1;
              out_valid_nxt = 1'b0;
            end
            FN_READ: begin
              if (!built_r) begin
                status_nxt = ST_PHASE;
              end else if (in_rank == '0 || in_rank > len_r) begin
                status_nxt = ST_RANK;
              end else begin
                // order store answers next cycle
                out_valid_nxt = 1'b0;
              end
            end
            FN_CLEAR: begin
              len_nxt   = '0;
              built_nxt = 1'b0;
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
          olen_nxt = len_nxt;
        end
      end
      T_READ: begin
        status_nxt    = ST_OK;
        pos_nxt       = sa_rdata + IdxW'(1);
        olen_nxt      = len_r;
        out_valid_nxt = 1'b1;
      end
      T_BUILD: begin
        if (done) begin
          built_nxt     = 1'b1;
          status_nxt    = ST_OK;
          pos_nxt       = '0;
          olen_nxt      = len_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

endmodule

>>> src/sapd_ram.sv
// ----------------------------------------------------------------------------
// sapd_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module sapd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/sapd_engine.sv
// ----------------------------------------------------------------------------
// sapd_engine
// prefix doubling sequencer over six stores, each with one write and one registered read port
// ----------------------------------------------------------------------------
module sapd_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [sapd_pkg::IdxW-1:0] len,
  input  sapd_pkg::host_t        host,
  output logic [sapd_pkg::IdxW-1:0] sa_rdata,
  output logic                   done
);
  import sapd_pkg::*;

  eng_state_t st_r, st_nxt;
  logic [1:0]      ph_r, ph_nxt;
  logic [CntW-1:0] i_r, i_nxt, k_r, k_nxt, n1_r, n1_nxt, acc_r, acc_nxt;
  logic            dbl_r, dbl_nxt;
  logic [IdxW-1:0] run_r, run_nxt, c_r, c_nxt, s_r, s_nxt;
  logic [IdxW-1:0] pc1_r, pc1_nxt, pc2_r, pc2_nxt;

  logic             tx_we, sa_we, cl_we, nc_we, sh_we, ct_we;
  logic [IdxW-1:0]  tx_wa, sa_wa, cl_wa, nc_wa, sh_wa, ct_wa;
  logic [IdxW-1:0]  tx_ra, sa_ra, cl_ra, nc_ra, sh_ra, ct_ra;
  logic [CodeW-1:0] tx_wd, tx_q;
  logic [IdxW-1:0]  sa_wd, cl_wd, nc_wd, sh_wd, sa_q, cl_q, nc_q, sh_q;
  logic [CntW-1:0]  ct_wd, ct_q;

  logic            last_fwd, at_zero, last_ps, differ;
  logic [CntW-1:0] bmax, sh_val, wrap_sum, k_dbl;
  logic [IdxW-1:0] run_inc;

  assign last_fwd = (i_r == n1_r - CntW'(1));
  assign at_zero  = (i_r == '0);
  assign bmax     = (n1_r > CntW'(AlphaCodes)) ? n1_r : CntW'(AlphaCodes);
  assign last_ps  = (i_r == bmax - CntW'(1));
  assign k_dbl    = {k_r[CntW-2:0], 1'b0};
  assign sh_val   = ({1'b0, sa_q} >= k_r) ? ({1'b0, sa_q} - k_r)
                                          : ({1'b0, sa_q} + n1_r - k_r);
  assign wrap_sum = ({1'b0, s_r} + k_r >= n1_r) ? ({1'b0, s_r} + k_r - n1_r)
                                                : ({1'b0, s_r} + k_r);
  assign differ   = (c_r != pc1_r) || (cl_q != pc2_r);
  assign sa_rdata = sa_q;
  assign done     = (st_r == S_DONE);

  sapd_ram #(.WIDTH(CodeW), .DEPTH(MaxLen)) u_text (
    .clk, .we(tx_we), .waddr(tx_wa), .wdata(tx_wd), .raddr(tx_ra), .rdata(tx_q));
  sapd_ram #(.WIDTH(IdxW), .DEPTH(MaxLen)) u_order (
    .clk, .we(sa_we), .waddr(sa_wa), .wdata(sa_wd), .raddr(sa_ra), .rdata(sa_q));
  sapd_ram #(.WIDTH(IdxW), .DEPTH(MaxLen)) u_class (
    .clk, .we(cl_we), .waddr(cl_wa), .wdata(cl_wd), .raddr(cl_ra), .rdata(cl_q));
  sapd_ram #(.WIDTH(IdxW), .DEPTH(MaxLen)) u_nclass (
    .clk, .we(nc_we), .waddr(nc_wa), .wdata(nc_wd), .raddr(nc_ra), .rdata(nc_q));
  sapd_ram #(.WIDTH(IdxW), .DEPTH(MaxLen)) u_shift (
    .clk, .we(sh_we), .waddr(sh_wa), .wdata(sh_wd), .raddr(sh_ra), .rdata(sh_q));
  sapd_ram #(.WIDTH(CntW), .DEPTH(MaxLen)) u_count (
    .clk, .we(ct_we), .waddr(ct_wa), .wdata(ct_wd), .raddr(ct_ra), .rdata(ct_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ph_r  <= '0;
      i_r   <= '0;
      dbl_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      ph_r  <= ph_nxt;
      i_r   <= i_nxt;
      dbl_r <= dbl_nxt;
    end
    k_r   <= k_nxt;
    n1_r  <= n1_nxt;
    acc_r <= acc_nxt;
    run_r <= run_nxt;
    c_r   <= c_nxt;
    s_r   <= s_nxt;
    pc1_r <= pc1_nxt;
    pc2_r <= pc2_nxt;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (start) st_nxt = S_SENT;
      S_SENT:  st_nxt = S_CLR;
      S_CLR:   if (i_r == CntW'(MaxLen - 1)) st_nxt = S_HIST;
      S_HIST:  if (ph_r == 2'd2 && last_fwd) st_nxt = S_PSUM;
      S_PSUM:  if (ph_r == 2'd1 && last_ps) st_nxt = dbl_r ? S_SCAT2 : S_SCAT;
      S_SCAT:  if (ph_r == 2'd2 && at_zero) st_nxt = S_CLS0;
      S_CLS0: begin
        if (ph_r == 2'd2 && last_fwd) st_nxt = (n1_r > CntW'(1)) ? S_SHIFT : S_DONE;
      end
      S_SHIFT: if (ph_r == 2'd1 && last_fwd) st_nxt = S_CLR;
      S_SCAT2: if (ph_r == 2'd3 && at_zero) st_nxt = S_RENUM;
      S_RENUM: if (ph_r == 2'd3 && last_fwd) st_nxt = S_COPY;
      S_COPY: begin
        if (ph_r == 2'd1 && last_fwd) st_nxt = (k_dbl < n1_r) ? S_SHIFT : S_DONE;
      end
      S_DONE:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // datapath and store ports
  always_comb begin
    ph_nxt  = ph_r + 2'd1;
    i_nxt   = i_r;
    k_nxt   = k_r;
    n1_nxt  = n1_r;
    dbl_nxt = dbl_r;
    acc_nxt = acc_r;
    run_nxt = run_r;
    c_nxt   = c_r;
    s_nxt   = s_r;
    pc1_nxt = pc1_r;
    pc2_nxt = pc2_r;
    run_inc = '0;
    tx_we = 1'b0; tx_wa = '0; tx_wd = '0; tx_ra = '0;
    sa_we = 1'b0; sa_wa = '0; sa_wd = '0; sa_ra = '0;
    cl_we = 1'b0; cl_wa = '0; cl_wd = '0; cl_ra = '0;
    nc_we = 1'b0; nc_wa = '0; nc_wd = '0; nc_ra = '0;
    sh_we = 1'b0; sh_wa = '0; sh_wd = '0; sh_ra = '0;
    ct_we = 1'b0; ct_wa = '0; ct_wd = '0; ct_ra = '0;
    case (st_r)
      S_IDLE: begin
        ph_nxt = '0;
        tx_we  = host.we;
        tx_wa  = host.waddr;
        tx_wd  = host.wdata;
        sa_ra  = host.raddr;
        if (start) begin
          n1_nxt  = {1'b0, len} + CntW'(1);
          dbl_nxt = 1'b0;
          k_nxt   = CntW'(1);
        end
      end
      S_SENT: begin
        // sentinel code after the last letter
        tx_we  = 1'b1;
        tx_wa  = n1_r[IdxW-1:0] - IdxW'(1);
        i_nxt  = '0;
        ph_nxt = '0;
      end
      S_CLR: begin
        ct_we  = 1'b1;
        ct_wa  = i_r[IdxW-1:0];
        ph_nxt = '0;
        i_nxt  = (i_r == CntW'(MaxLen - 1)) ? '0 : i_r + CntW'(1);
      end
      S_HIST: begin
        tx_ra = i_r[IdxW-1:0];
        cl_ra = i_r[IdxW-1:0];
        if (ph_r == 2'd1) begin
          c_nxt = dbl_r ? cl_q : IdxW'(tx_q);
          ct_ra = c_nxt;
        end
        if (ph_r == 2'd2) begin
          ct_we  = 1'b1;
          ct_wa  = c_r;
          ct_wd  = ct_q + CntW'(1);
          ph_nxt = '0;
          i_nxt  = last_fwd ? '0 : i_r + CntW'(1);
          if (last_fwd) acc_nxt = '0;
        end
      end
      S_PSUM: begin
        ct_ra = i_r[IdxW-1:0];
        if (ph_r == 2'd1) begin
          acc_nxt = acc_r + ct_q;
          ct_we   = 1'b1;
          ct_wa   = i_r[IdxW-1:0];
          ct_wd   = acc_nxt;
          ph_nxt  = '0;
          i_nxt   = last_ps ? n1_r - CntW'(1) : i_r + CntW'(1);
        end
      end
      S_SCAT: begin
        tx_ra = i_r[IdxW-1:0];
        if (ph_r == 2'd1) begin
          c_nxt = IdxW'(tx_q);
          ct_ra = c_nxt;
        end
        if (ph_r == 2'd2) begin
          ct_we  = 1'b1;
          ct_wa  = c_r;
          ct_wd  = ct_q - CntW'(1);
          sa_we  = 1'b1;
          sa_wa  = ct_wd[IdxW-1:0];
          sa_wd  = i_r[IdxW-1:0];
          ph_nxt = '0;
          i_nxt  = at_zero ? '0 : i_r - CntW'(1);
        end
      end
      S_CLS0: begin
        sa_ra = i_r[IdxW-1:0];
        if (ph_r == 2'd1) begin
          s_nxt = sa_q;
          tx_ra = sa_q;
        end
        if (ph_r == 2'd2) begin
          run_inc = (IdxW'(tx_q) != pc1_r) ? IdxW'(1) : '0;
          run_nxt = at_zero ? '0 : run_r + run_inc;
          pc1_nxt = IdxW'(tx_q);
          cl_we   = 1'b1;
          cl_wa   = s_r;
          cl_wd   = run_nxt;
          ph_nxt  = '0;
          i_nxt   = last_fwd ? '0 : i_r + CntW'(1);
        end
      end
      S_SHIFT: begin
        sa_ra = i_r[IdxW-1:0];
        if (ph_r == 2'd1) begin
          sh_we  = 1'b1;
          sh_wa  = i_r[IdxW-1:0];
          sh_wd  = sh_val[IdxW-1:0];
          ph_nxt = '0;
          i_nxt  = last_fwd ? '0 : i_r + CntW'(1);
          if (last_fwd) dbl_nxt = 1'b1;
        end
      end
      S_SCAT2: begin
        sh_ra = i_r[IdxW-1:0];
        if (ph_r == 2'd1) begin
          s_nxt = sh_q;
          cl_ra = sh_q;
        end
        if (ph_r == 2'd2) begin
          c_nxt = cl_q;
          ct_ra = cl_q;
        end
        if (ph_r == 2'd3) begin
          ct_we  = 1'b1;
          ct_wa  = c_r;
          ct_wd  = ct_q - CntW'(1);
          sa_we  = 1'b1;
          sa_wa  = ct_wd[IdxW-1:0];
          sa_wd  = s_r;
          ph_nxt = '0;
          i_nxt  = at_zero ? '0 : i_r - CntW'(1);
        end
      end
      S_RENUM: begin
        sa_ra = i_r[IdxW-1:0];
        if (ph_r == 2'd1) begin
          s_nxt = sa_q;
          cl_ra = sa_q;
        end
        if (ph_r == 2'd2) begin
          c_nxt = cl_q;
          cl_ra = wrap_sum[IdxW-1:0];
        end
        if (ph_r == 2'd3) begin
          run_inc = differ ? IdxW'(1) : '0;
          run_nxt = at_zero ? '0 : run_r + run_inc;
          pc1_nxt = c_r;
          pc2_nxt = cl_q;
          nc_we   = 1'b1;
          nc_wa   = s_r;
          nc_wd   = run_nxt;
          i_nxt   = last_fwd ? '0 : i_r + CntW'(1);
        end
      end
      S_COPY: begin
        nc_ra = i_r[IdxW-1:0];
        if (ph_r == 2'd1) begin
          cl_we  = 1'b1;
          cl_wa  = i_r[IdxW-1:0];
          cl_wd  = nc_q;
          ph_nxt = '0;
          i_nxt  = last_fwd ? '0 : i_r + CntW'(1);
          if (last_fwd) k_nxt = k_dbl;
        end
      end
      S_DONE: begin
        ph_nxt = '0;
        i_nxt  = '0;
      end
      default: begin
        ph_nxt = '0;
      end
    endcase
  end

endmodule
